// File: hdl/midpoint_line_rasterizer_macros.svh
// Assertion helpers used by the rasterizer top level.
`ifndef MIDPOINT_LINE_RASTERIZER_MACROS_SVH
`define MIDPOINT_LINE_RASTERIZER_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define MLR_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rasterizer assertion failed");

// Check that cons holds in the cycle after ante.
`define MLR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rasterizer assertion failed");

`endif

// File: hdl/mlr_pkg.sv
package mlr_pkg;

  // Coordinate width and derived widths
  localparam int COORD_BITS = 12;
  localparam int SPAN_BITS  = COORD_BITS + 1;
  // Decision term stays within a few multiples of 2*span
  localparam int ERR_BITS   = COORD_BITS + 5;
  localparam int COLOR_BITS = 32;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [SPAN_BITS-1:0]  span_t;
  typedef logic [COLOR_BITS-1:0] color_t;

  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_ADVANCE = 1'b1
  } opcode_e;

  // One input item as held in the input register
  typedef struct packed {
    opcode_e op;
    coord_t  x_start;
    coord_t  y_start;
    coord_t  x_end;
    coord_t  y_end;
    color_t  color;
  } cmd_t;

  // One pixel produced by the stepper
  typedef struct packed {
    logic   valid;
    coord_t x;
    coord_t y;
    color_t color;
    logic   last;
  } pix_t;

endpackage

// File: hdl/mlr_stepper.sv
module mlr_stepper (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_en_i,
  input  mlr_pkg::cmd_t cmd_i,
  output mlr_pkg::pix_t pix_o,
  output logic          busy_o
);

  localparam int CB = mlr_pkg::COORD_BITS;
  localparam int SB = mlr_pkg::SPAN_BITS;
  localparam int EB = mlr_pkg::ERR_BITS;

  mlr_pkg::coord_t cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  mlr_pkg::coord_t goal_x_q, goal_x_d, goal_y_q, goal_y_d;
  mlr_pkg::span_t  span_x_q, span_x_d, span_y_q, span_y_d;
  logic            vert_q, vert_d, steep_q, steep_d, fall_q, fall_d;
  logic            busy_q, busy_d;
  mlr_pkg::color_t color_q, color_d;
  logic signed [EB-1:0] err_q, err_d;

  // Load: order the endpoints, pick octant rule, seed the decision term
  mlr_pkg::coord_t lx0, ly0, lx1, ly1;
  logic            ld_vert, ld_swap, ld_fall, ld_steep;
  mlr_pkg::span_t  ld_dx, ld_dy;
  logic signed [EB-1:0] ld_dx_e, ld_dy_e, ld_err;

  always_comb begin
    ld_vert  = (cmd_i.x_start == cmd_i.x_end);
    ld_swap  = (cmd_i.x_start > cmd_i.x_end);
    lx0      = ld_swap ? cmd_i.x_end   : cmd_i.x_start;
    ly0      = ld_swap ? cmd_i.y_end   : cmd_i.y_start;
    lx1      = ld_swap ? cmd_i.x_start : cmd_i.x_end;
    ly1      = ld_swap ? cmd_i.y_start : cmd_i.y_end;
    ld_fall  = (ly1 < ly0);
    ld_dx    = SB'(lx1) - SB'(lx0);
    ld_dy    = ld_fall ? (SB'(ly0) - SB'(ly1)) : (SB'(ly1) - SB'(ly0));
    ld_steep = (ld_dy > ld_dx);
    ld_dx_e  = $signed(EB'(ld_dx));
    ld_dy_e  = $signed(EB'(ld_dy));
    unique case ({ld_steep, ld_fall})
      2'b00:   ld_err = ld_dx_e - (ld_dy_e <<< 1);
      2'b01:   ld_err = (ld_dy_e <<< 1) - ld_dx_e;
      2'b10:   ld_err = (ld_dx_e <<< 1) - ld_dy_e;
      default: ld_err = ld_dy_e - (ld_dx_e <<< 1);
    endcase
  end

  // Advance: one midpoint decision and an incremental update of the term
  logic                 nonneg, sx, sy_up, sy_dn;
  logic signed [EB-1:0] dx2, dy2, err_adv;
  mlr_pkg::coord_t      nx, ny;

  always_comb begin
    nonneg = ~err_q[EB-1];
    if (!steep_q) begin
      sx    = 1'b1;
      sy_up = ~fall_q & ~nonneg;
      sy_dn = fall_q & nonneg;
    end else begin
      sx    = fall_q ? ~nonneg : nonneg;
      sy_up = ~fall_q;
      sy_dn = fall_q;
    end
    dx2     = $signed(EB'({span_x_q, 1'b0}));
    dy2     = $signed(EB'({span_y_q, 1'b0}));
    err_adv = err_q;
    if (sy_up) err_adv = err_adv + dx2;
    if (sy_dn) err_adv = err_adv - dx2;
    // 2*s term: s is negative when falling
    if (sx)    err_adv = fall_q ? (err_adv + dy2) : (err_adv - dy2);
    if (vert_q) begin
      nx = cur_x_q;
      ny = cur_y_q + CB'(1);
    end else begin
      nx = cur_x_q + CB'(sx);
      ny = sy_up ? (cur_y_q + CB'(1)) : (sy_dn ? (cur_y_q - CB'(1)) : cur_y_q);
    end
  end

  // Next state and pixel
  always_comb begin
    cur_x_d  = cur_x_q;
    cur_y_d  = cur_y_q;
    goal_x_d = goal_x_q;
    goal_y_d = goal_y_q;
    span_x_d = span_x_q;
    span_y_d = span_y_q;
    vert_d   = vert_q;
    steep_d  = steep_q;
    fall_d   = fall_q;
    busy_d   = busy_q;
    color_d  = color_q;
    err_d    = err_q;
    pix_o.valid = 1'b0;
    pix_o.x     = nx;
    pix_o.y     = ny;
    pix_o.color = color_q;
    pix_o.last  = (nx == goal_x_q) && (ny == goal_y_q);
    if (step_en_i) begin
      if (cmd_i.op == mlr_pkg::OP_LOAD) begin
        color_d = cmd_i.color;
        busy_d  = 1'b1;
        vert_d  = ld_vert;
        if (ld_vert) begin
          steep_d  = 1'b0;
          fall_d   = 1'b0;
          cur_x_d  = cmd_i.x_start;
          goal_x_d = cmd_i.x_start;
          cur_y_d  = (ld_fall ? ly1 : ly0) - CB'(1);
          goal_y_d = ld_fall ? ly0 : ly1;
          span_x_d = '0;
          span_y_d = ld_dy;
          err_d    = '0;
        end else begin
          steep_d  = ld_steep;
          fall_d   = ld_fall;
          cur_x_d  = lx0;
          cur_y_d  = ly0;
          goal_x_d = lx1;
          goal_y_d = ly1;
          span_x_d = ld_dx;
          span_y_d = ld_dy;
          err_d    = ld_err;
        end
      end else if (busy_q) begin
        pix_o.valid = 1'b1;
        cur_x_d     = nx;
        cur_y_d     = ny;
        err_d       = err_adv;
        busy_d      = ~pix_o.last;
      end
    end
  end

  // Hold line state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q  <= '0;
      cur_y_q  <= '0;
      goal_x_q <= '0;
      goal_y_q <= '0;
      span_x_q <= '0;
      span_y_q <= '0;
      vert_q   <= 1'b0;
      steep_q  <= 1'b0;
      fall_q   <= 1'b0;
      busy_q   <= 1'b0;
      color_q  <= '0;
      err_q    <= '0;
    end else begin
      cur_x_q  <= cur_x_d;
      cur_y_q  <= cur_y_d;
      goal_x_q <= goal_x_d;
      goal_y_q <= goal_y_d;
      span_x_q <= span_x_d;
      span_y_q <= span_y_d;
      vert_q   <= vert_d;
      steep_q  <= steep_d;
      fall_q   <= fall_d;
      busy_q   <= busy_d;
      color_q  <= color_d;
      err_q    <= err_d;
    end
  end

  assign busy_o = busy_q;

endmodule

// File: hdl/midpoint_line_rasterizer.sv
// Path: an accepted advance item is held in the input register, and the pixel item
//   it plots then in the result register, which drives the output.
// Throughput: one item and one stepper decision per clock unless output stalls.
// Reset (rst_ni low, asynchronous): line state cleared to zero, stepper idle,
//   both channels empty.
module midpoint_line_rasterizer (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             opcode_i,
  input  logic [mlr_pkg::COORD_BITS-1:0]   x_start_i,
  input  logic [mlr_pkg::COORD_BITS-1:0]   y_start_i,
  input  logic [mlr_pkg::COORD_BITS-1:0]   x_end_i,
  input  logic [mlr_pkg::COORD_BITS-1:0]   y_end_i,
  input  logic [mlr_pkg::COLOR_BITS-1:0]   line_color_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [mlr_pkg::COORD_BITS-1:0]   pixel_x_o,
  output logic [mlr_pkg::COORD_BITS-1:0]   pixel_y_o,
  output logic [mlr_pkg::COLOR_BITS-1:0]   pixel_color_o,
  output logic                             last_o
);

  logic          in_valid_q, in_valid_d;
  mlr_pkg::cmd_t cmd_q, cmd_d;
  logic          out_valid_q, out_valid_d;
  mlr_pkg::pix_t pix_q, pix_d;
  mlr_pkg::pix_t step_pix;
  logic          step_en, in_fire, busy;

  // Process the held item when the result register is free or draining
  assign step_en    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || step_en;
  assign in_fire    = in_valid_i && in_ready_o;

  mlr_stepper u_stepper (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (step_en),
    .cmd_i     (cmd_q),
    .pix_o     (step_pix),
    .busy_o    (busy)
  );

  // Capture the next item; load a result or drop the one taken
  always_comb begin
    in_valid_d = in_fire || (in_valid_q && !step_en);
    cmd_d      = cmd_q;
    if (in_fire) begin
      cmd_d.op      = mlr_pkg::opcode_e'(opcode_i);
      cmd_d.x_start = x_start_i;
      cmd_d.y_start = y_start_i;
      cmd_d.x_end   = x_end_i;
      cmd_d.y_end   = y_end_i;
      cmd_d.color   = line_color_i;
    end
    pix_d       = pix_q;
    out_valid_d = out_valid_q;
    if (step_pix.valid) begin
      pix_d       = step_pix;
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    pix_q <= pix_d;
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_x_o     = pix_q.x;
  assign pixel_y_o     = pix_q.y;
  assign pixel_color_o = pix_q.color;
  assign last_o        = pix_q.last;

`include "midpoint_line_rasterizer_macros.svh"

  `MLR_ASSERT_SAME(a_result_from_advance, $rose(out_valid_q),
    $past(in_valid_q) && ($past(cmd_q.op) == mlr_pkg::OP_ADVANCE))
  `MLR_ASSERT_NEXT(a_idle_after_last, step_pix.valid && step_pix.last, !busy)
  `MLR_ASSERT_NEXT(a_hold_on_stall, in_valid_q && out_valid_q && !out_ready_i,
    in_valid_q && $stable(cmd_q))
  `MLR_ASSERT_SAME(a_pixel_needs_busy, step_pix.valid, busy && step_en)

endmodule

// File: tb/sv/midpoint_line_rasterizer_tb.sv
`timescale 1ns / 100ps

module midpoint_line_rasterizer_tb;
  import mlr_pkg::*;

  localparam int COORD_MAX     = (1 << COORD_BITS) - 1;
  localparam int ITEM_TARGET   = 775;
  localparam int STEADY_ITEMS  = 200;
  localparam int HOLDOFF_LEN   = 300;
  localparam int STALL_LIMIT   = 4000;
  localparam int DRAIN_CYCLES  = 8;

  typedef struct packed {
    coord_t x;
    coord_t y;
    color_t color;
    logic   last;
  } pixel_t;

  typedef struct packed {
    opcode_e op;
    coord_t  xs;
    coord_t  ys;
    coord_t  xe;
    coord_t  ye;
    color_t  col;
    logic    typed;
    pixel_t  px;
  } dir_row_t;

  localparam pixel_t NO_PIX = '0;
  localparam int DIR_N = 24;

  // Directed rows: typed pixels only where they follow at a glance
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    // advance straight after reset: ignored
    '{OP_ADVANCE, 12'd0,    12'd0,    12'd0,    12'd0,    32'h0000_0000, 1'b0, NO_PIX},
    // single point at the top corner
    '{OP_LOAD,    12'd4095, 12'd4095, 12'd4095, 12'd4095, 32'hFFFF_FFFF, 1'b0, NO_PIX},
    '{OP_ADVANCE, 12'd0,    12'd0,    12'd0,    12'd0,    32'h0000_0000, 1'b1,
      '{12'd4095, 12'd4095, 32'hFFFF_FFFF, 1'b1}},
    // line done: ignored
    '{OP_ADVANCE, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 32'hFFFF_FFFF, 1'b0, NO_PIX},
    // vertical line given top-down, wraps up from the last row to row zero
    '{OP_LOAD,    12'd0,    12'd1,    12'd0,    12'd0,    32'h0000_0000, 1'b0, NO_PIX},
    '{OP_ADVANCE, 12'd0,    12'd0,    12'd0,    12'd0,    32'h0000_0000, 1'b1,
      '{12'd0, 12'd0, 32'h0000_0000, 1'b0}},
    '{OP_ADVANCE, 12'd0,    12'd0,    12'd0,    12'd0,    32'h0000_0000, 1'b1,
      '{12'd0, 12'd1, 32'h0000_0000, 1'b1}},
    // shallow rising
    '{OP_LOAD,    12'd0,    12'd0,    12'd3,    12'd1,    32'h1234_5678, 1'b0, NO_PIX},
    '{OP_ADVANCE, 12'd0,    12'd0,    12'd0,    12'd0,    32'h0000_0000, 1'b0, NO_PIX},
    '{OP_ADVANCE, 12'd0,    12'd0,    12'd0,    12'd0,    32'h0000_0000, 1'b0, NO_PIX},
    '{OP_ADVANCE, 12'd0,    12'd0,    12'd0,    12'd0,    32'h0000_0000, 1'b0, NO_PIX},
    // shallow falling given right to left, advances carry junk load fields
    '{OP_LOAD,    12'd4095, 12'd0,    12'd4092, 12'd2,    32'hDEAD_BEEF, 1'b0, NO_PIX},
    '{OP_ADVANCE, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 32'hFFFF_FFFF, 1'b0, NO_PIX},
    '{OP_ADVANCE, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 32'hFFFF_FFFF, 1'b0, NO_PIX},
    '{OP_ADVANCE, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 32'hFFFF_FFFF, 1'b0, NO_PIX},
    // steep rising
    '{OP_LOAD,    12'd10,   12'd10,   12'd11,   12'd13,   32'hA5A5_A5A5, 1'b0, NO_PIX},
    '{OP_ADVANCE, 12'd0,    12'd0,    12'd0,    12'd0,    32'h0000_0000, 1'b0, NO_PIX},
    '{OP_ADVANCE, 12'd0,    12'd0,    12'd0,    12'd0,    32'h0000_0000, 1'b0, NO_PIX},
    // steep falling from the top row, cut short by the next load
    '{OP_LOAD,    12'd20,   12'd4095, 12'd21,   12'd4092, 32'h5A5A_5A5A, 1'b0, NO_PIX},
    '{OP_ADVANCE, 12'd0,    12'd0,    12'd0,    12'd0,    32'h0000_0000, 1'b0, NO_PIX},
    // horizontal line
    '{OP_LOAD,    12'd5,    12'd7,    12'd7,    12'd7,    32'h0000_0000, 1'b0, NO_PIX},
    '{OP_ADVANCE, 12'd0,    12'd0,    12'd0,    12'd0,    32'h0000_0000, 1'b1,
      '{12'd6, 12'd7, 32'h0000_0000, 1'b0}},
    '{OP_ADVANCE, 12'd0,    12'd0,    12'd0,    12'd0,    32'h0000_0000, 1'b1,
      '{12'd7, 12'd7, 32'h0000_0000, 1'b1}},
    '{OP_ADVANCE, 12'd0,    12'd0,    12'd0,    12'd0,    32'h0000_0000, 1'b0, NO_PIX}
  };

  logic   clk_i = 1'b0;
  logic   rst_ni;
  logic   in_valid_i;
  logic   in_ready_o;
  logic   opcode_i;
  coord_t x_start_i;
  coord_t y_start_i;
  coord_t x_end_i;
  coord_t y_end_i;
  color_t line_color_i;
  logic   out_valid_o;
  logic   out_ready_i;
  coord_t pixel_x_o;
  coord_t pixel_y_o;
  color_t pixel_color_o;
  logic   last_o;

  // Line state of the predictor
  coord_t ln_cur_x, ln_cur_y, ln_goal_x, ln_goal_y;
  span_t  ln_span_x, ln_span_y;
  bit     ln_vert, ln_steep, ln_fall;
  color_t ln_color;
  bit     ln_busy;

  pixel_t pending_pixels [$];
  int     err_count;
  int     items_sent;
  int     stall_cycles;
  int     holdoff_request;
  bit     steady;

  midpoint_line_rasterizer u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .opcode_i      (opcode_i),
    .x_start_i     (x_start_i),
    .y_start_i     (y_start_i),
    .x_end_i       (x_end_i),
    .y_end_i       (y_end_i),
    .line_color_i  (line_color_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .pixel_color_o (pixel_color_o),
    .last_o        (last_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Apply one item to the predicted line state, return the pixel it plots
  task automatic step_line(input opcode_e op, input coord_t xs, input coord_t ys,
                           input coord_t xe, input coord_t ye, input color_t col,
                           output bit emit, output pixel_t px);
    coord_t ax, ay, bx, by, tmp;
    longint x, y, gx, gy, dx, s, dd, e;
    int     sx, sy;
    emit = 1'b0;
    px   = '0;
    if (op == OP_LOAD) begin
      ax = xs; ay = ys; bx = xe; by = ye;
      ln_color = col;
      ln_busy  = 1'b1;
      if (ax == bx) begin
        if (ay > by) begin
          tmp = ay; ay = by; by = tmp;
        end
        ln_vert   = 1'b1;
        ln_steep  = 1'b0;
        ln_fall   = 1'b0;
        ln_cur_x  = ax;
        ln_goal_x = ax;
        ln_cur_y  = ay - 1'b1;
        ln_goal_y = by;
        ln_span_x = '0;
        ln_span_y = span_t'(by) - span_t'(ay);
      end else begin
        // order left to right
        if (ax > bx) begin
          tmp = ax; ax = bx; bx = tmp;
          tmp = ay; ay = by; by = tmp;
        end
        ln_cur_x  = ax;
        ln_cur_y  = ay;
        ln_goal_x = bx;
        ln_goal_y = by;
        ln_span_x = span_t'(bx) - span_t'(ax);
        ln_vert   = 1'b0;
        ln_fall   = (by < ay);
        ln_span_y = ln_fall ? span_t'(ay) - span_t'(by) : span_t'(by) - span_t'(ay);
        ln_steep  = (ln_span_y > ln_span_x);
      end
    end else if (ln_busy) begin
      if (ln_vert) begin
        ln_cur_y = ln_cur_y + 1'b1;
      end else begin
        // exact midpoint decision, scaled by 2*dx
        x  = longint'(ln_cur_x);
        y  = longint'(ln_cur_y);
        gx = longint'(ln_goal_x);
        gy = longint'(ln_goal_y);
        dx = longint'(ln_span_x);
        s  = ln_fall ? -longint'(ln_span_y) : longint'(ln_span_y);
        dd = ln_fall ? -1 : 1;
        if (!ln_steep) begin
          e  = 2 * dx * (y - gy) + dd * dx - 2 * s * (x + 1 - gx);
          sx = 1;
          if (e >= 0) sy = ln_fall ? -1 : 0;
          else sy = ln_fall ? 0 : 1;
        end else begin
          e  = 2 * dx * (y - gy) + 2 * dd * dx - s * (2 * (x - gx) + 1);
          sy = ln_fall ? -1 : 1;
          if (e >= 0) sx = ln_fall ? 0 : 1;
          else sx = ln_fall ? 1 : 0;
        end
        ln_cur_x = ln_cur_x + coord_t'(sx);
        if (sy > 0) ln_cur_y = ln_cur_y + 1'b1;
        else if (sy < 0) ln_cur_y = ln_cur_y - 1'b1;
      end
      emit     = 1'b1;
      px.x     = ln_cur_x;
      px.y     = ln_cur_y;
      px.color = ln_color;
      px.last  = (ln_cur_x == ln_goal_x) && (ln_cur_y == ln_goal_y);
      if (px.last) ln_busy = 1'b0;
    end
  endtask

  // Offer one item, wait for its acceptance, then record what it should plot
  task automatic send_item(input opcode_e op, input coord_t xs, input coord_t ys,
                           input coord_t xe, input coord_t ye, input color_t col,
                           input bit typed, input pixel_t typed_px);
    bit     emit;
    pixel_t px;
    in_valid_i   <= 1'b1;
    opcode_i     <= op;
    x_start_i    <= xs;
    y_start_i    <= ys;
    x_end_i      <= xe;
    y_end_i      <= ye;
    line_color_i <= col;
    do @(posedge clk_i); while (!in_ready_o);
    if (op == OP_LOAD || ln_busy) items_sent++;
    step_line(op, xs, ys, xe, ye, col, emit, px);
    if (typed) pending_pixels.push_back(typed_px);
    else if (emit) pending_pixels.push_back(px);
    // random one-cycle gap on the input side
    if (!steady && $urandom_range(99) < 12) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // Random coordinate within reach of base, clipped to the grid
  function automatic coord_t near_coord(input int base, input int reach);
    int v;
    v = base + int'($urandom_range(0, 2 * reach)) - reach;
    if (v < 0) v = 0;
    if (v > COORD_MAX) v = COORD_MAX;
    return coord_t'(v);
  endfunction

  // Receiver: random stalls, steady stretch, and one long hold-off on request
  always @(posedge clk_i) begin : rx_ready
    int holdoff_left;
    if (!rst_ni) begin
      out_ready_i  <= 1'b0;
      holdoff_left = 0;
    end else begin
      if (holdoff_request > 0) begin
        holdoff_left    = holdoff_request;
        holdoff_request = 0;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        out_ready_i <= 1'b0;
      end else if (steady) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(99) >= 12);
      end
    end
  end

  // Compare each accepted pixel with the oldest prediction
  always @(posedge clk_i) begin : pixel_check
    pixel_t exp_px;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected pixel x=%0d y=%0d color=%h last=%0b",
               pixel_x_o, pixel_y_o, pixel_color_o, last_o);
        err_count++;
      end else begin
        exp_px = pending_pixels.pop_front();
        if (pixel_x_o !== exp_px.x) begin
          $error("pixel_x mismatch: expected %0d, actual %0d", exp_px.x, pixel_x_o);
          err_count++;
        end
        if (pixel_y_o !== exp_px.y) begin
          $error("pixel_y mismatch: expected %0d, actual %0d", exp_px.y, pixel_y_o);
          err_count++;
        end
        if (pixel_color_o !== exp_px.color) begin
          $error("pixel_color mismatch: expected %h, actual %h",
                 exp_px.color, pixel_color_o);
          err_count++;
        end
        if (last_o !== exp_px.last) begin
          $error("last mismatch: expected %0b, actual %0b", exp_px.last, last_o);
          err_count++;
        end
      end
    end
  end

  // Count cycles in which neither channel moves an item
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  initial begin : watchdog
    while (stall_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    int     kind, shape, guard;
    int     steady_end;
    coord_t xs, ys, xe, ye;
    color_t col;

    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    opcode_i        = OP_LOAD;
    x_start_i       = '0;
    y_start_i       = '0;
    x_end_i         = '0;
    y_end_i         = '0;
    line_color_i    = '0;
    out_ready_i     = 1'b0;
    err_count       = 0;
    items_sent      = 0;
    stall_cycles    = 0;
    holdoff_request = 0;
    steady          = 1'b0;

    ln_cur_x  = '0; ln_cur_y  = '0; ln_goal_x = '0; ln_goal_y = '0;
    ln_span_x = '0; ln_span_y = '0;
    ln_vert   = 1'b0; ln_steep = 1'b0; ln_fall = 1'b0;
    ln_color  = '0;
    ln_busy   = 1'b0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table
    for (int i = 0; i < DIR_N; i++) begin
      send_item(DIR_ROWS[i].op, DIR_ROWS[i].xs, DIR_ROWS[i].ys, DIR_ROWS[i].xe,
                DIR_ROWS[i].ye, DIR_ROWS[i].col, DIR_ROWS[i].typed, DIR_ROWS[i].px);
    end

    // Backpressure: receiver holds off while a long line keeps the input busy
    steady          = 1'b1;
    holdoff_request = HOLDOFF_LEN;
    send_item(OP_LOAD, 12'd100, 12'd200, 12'd160, 12'd230, 32'h0F0F_F0F0, 1'b0, NO_PIX);
    guard = 0;
    while (ln_busy && guard < 100) begin
      send_item(OP_ADVANCE, '0, '0, '0, '0, '0, 1'b0, NO_PIX);
      guard++;
    end

    // Random lines: mostly full sequences, some cut short, some noise
    steady_end = items_sent + STEADY_ITEMS;
    while (items_sent < ITEM_TARGET) begin
      steady = (items_sent < steady_end);
      kind   = $urandom_range(99);
      if (kind < 12) begin
        send_item(OP_ADVANCE, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                  coord_t'($urandom), color_t'($urandom), 1'b0, NO_PIX);
      end else begin
        shape = $urandom_range(9);
        xs    = coord_t'($urandom_range(0, COORD_MAX));
        ys    = coord_t'($urandom_range(0, COORD_MAX));
        col   = color_t'($urandom);
        if (shape == 0) begin
          xe = xs; ye = ys;
        end else if (shape <= 2) begin
          xe = xs; ye = near_coord(ys, 12);
        end else if (shape == 3) begin
          xe = coord_t'($urandom_range(0, COORD_MAX));
          ye = coord_t'($urandom_range(0, COORD_MAX));
        end else begin
          xe = near_coord(xs, 12);
          ye = near_coord(ys, 12);
        end
        send_item(OP_LOAD, xs, ys, xe, ye, col, 1'b0, NO_PIX);
        if (kind < 85) begin
          // full line, then maybe one advance past the end
          guard = 0;
          while (ln_busy && guard < 40) begin
            send_item(OP_ADVANCE, coord_t'($urandom), coord_t'($urandom), '0, '0,
                      color_t'($urandom), 1'b0, NO_PIX);
            guard++;
          end
          if ($urandom_range(3) == 0) send_item(OP_ADVANCE, '0, '0, '0, '0, '0, 1'b0, NO_PIX);
        end else begin
          // cut short by the next load
          repeat ($urandom_range(0, 3)) send_item(OP_ADVANCE, '0, '0, '0, '0, '0, 1'b0, NO_PIX);
        end
      end
    end

    // Drain and let any stray pixel show up
    steady = 1'b0;
    in_valid_i <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+hdl
hdl/mlr_pkg.sv
hdl/mlr_stepper.sv
hdl/midpoint_line_rasterizer.sv
tb/sv/midpoint_line_rasterizer_tb.sv
